### rtl/ucf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucf_pkg
// Shared constants, types and helper functions for the UTF-8 code point
// range filter.
// ----------------------------------------------------------------------------
package ucf_pkg;

	localparam int OUT_LIMIT  = 510;
	localparam int CNT_W      = $clog2(OUT_LIMIT + 2);
	localparam int NUM_RANGES = 20;
	localparam int CP_W       = 21;

	typedef logic [CP_W-1:0]  cp_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [7:0]       byte_t;

	localparam cp_t RANGE_LO [NUM_RANGES] = '{
		21'h00000, 21'h0000B, 21'h0000E, 21'h0007F, 21'h02700,
		21'h1F600, 21'h1F300, 21'h1F900, 21'h1F680, 21'h02600,
		21'h02300, 21'h02190, 21'h02E80, 21'h03000, 21'hE0000,
		21'hFE000, 21'h0FE00, 21'h0200B, 21'h02028, 21'h02060
	};

	localparam cp_t RANGE_HI [NUM_RANGES] = '{
		21'h00008, 21'h0000C, 21'h0001F, 21'h0009F, 21'h027BF,
		21'h1F64F, 21'h1F5FF, 21'h1F9FF, 21'h1F6FF, 21'h026FF,
		21'h023FF, 21'h021FF, 21'h02EFF, 21'h0303F, 21'hE007F,
		21'hFE0FF, 21'h0FE0F, 21'h0200F, 21'h0202E, 21'h02064
	};

	// Returns 1 when the code point falls inside any of the removed ranges.
	function automatic logic cp_removed(input cp_t cp);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_RANGES; i++) begin
			if (cp >= RANGE_LO[i] && cp <= RANGE_HI[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// Sequence length announced by a lead byte, or zero if it cannot start one.
	function automatic logic [2:0] lead_len(input byte_t b);
		logic [2:0] len;
		if (b[7] == 1'b0) begin
			len = 3'd1;
		end else if (b[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

endpackage
`default_nettype wire

### rtl/ucf_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucf_in_if
// Valid/ready channel carrying one raw input byte per item.
// ----------------------------------------------------------------------------
interface ucf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface
`default_nettype wire

### rtl/ucf_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucf_out_if
// Valid/ready channel carrying one filtered output byte per item.
// ----------------------------------------------------------------------------
interface ucf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       out_last;

	modport source (output valid, output out_byte, output byte_valid, output out_last,
		input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input out_last,
		output ready);
endinterface
`default_nettype wire

### rtl/utf8_codepoint_range_filter.sv
`default_nettype none
// An accepted item passes through the input register, then the output register.
// Throughput: one input item per cycle while each item yields at most one output
// item and the output is ready; an item that completes n kept bytes holds the
// output register until all are taken; the input register holds the next item.
// Reset clears the decoder state, byte count and both valid flags at once.
// ----------------------------------------------------------------------------
// utf8_codepoint_range_filter
// Decodes a UTF-8 byte stream, drops stray bytes, broken sequences and those whose
// code point is in a set of fixed ranges, and passes the rest byte for byte up to a limit.
// ----------------------------------------------------------------------------
module utf8_codepoint_range_filter
	import ucf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	ucf_in_if.sink     in_ch,
	ucf_out_if.source  out_ch
);

	logic               valid_s1;
	byte_t              byte_s1;
	logic               last_s1;

	logic [2:0][7:0]    held_q;
	logic [2:0]         need_q;
	logic [2:0]         have_q;
	cnt_t               cnt_q;

	logic [3:0][7:0]    buf_q;
	logic [2:0]         rem_q;
	logic [1:0]         idx_q;
	logic               buf_last_q;
	logic               marker_q;

	logic               buf_free;
	logic               proc;
	logic               out_fire;

	logic [2:0][7:0]    held_d;
	logic [2:0]         need_d;
	logic [2:0]         have_d;
	logic               fin;
	logic [2:0]         fin_len;
	logic [3:0][7:0]    fin_seq;
	logic [2:0]         start_len;
	cp_t                cp;
	cnt_t               avail;
	logic [2:0]         n_emit;
	logic [2:0]         n_total;

	assign out_fire = out_ch.valid && out_ch.ready;
	assign buf_free = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ch.ready);
	assign proc     = valid_s1 && buf_free;
	assign in_ch.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	always_comb begin
		held_d    = held_q;
		need_d    = need_q;
		have_d    = have_q;
		fin       = 1'b0;
		fin_len   = 3'd1;
		fin_seq   = '0;
		start_len = lead_len(byte_s1);
		if (need_q != 3'd0 && byte_s1[7:6] == 2'b10) begin
			if (have_q + 3'd1 >= need_q) begin
				fin        = 1'b1;
				fin_len    = need_q;
				fin_seq[0] = held_q[0];
				fin_seq[1] = held_q[1];
				fin_seq[2] = held_q[2];
				fin_seq[need_q[1:0] - 2'd1] = byte_s1;
				need_d     = 3'd0;
				have_d     = 3'd0;
			end else begin
				held_d[have_q[1:0]] = byte_s1;
				have_d = have_q + 3'd1;
			end
		end else begin
			need_d = 3'd0;
			have_d = 3'd0;
			if (cnt_q < cnt_t'(OUT_LIMIT) && start_len != 3'd0) begin
				if (start_len == 3'd1) begin
					fin        = 1'b1;
					fin_len    = 3'd1;
					fin_seq[0] = byte_s1;
				end else begin
					held_d[0] = byte_s1;
					need_d    = start_len;
					have_d    = 3'd1;
				end
			end
		end
	end

	always_comb begin
		case (fin_len)
			3'd1:    cp = {13'd0, fin_seq[0]};
			3'd2:    cp = {10'd0, fin_seq[0][4:0], fin_seq[1][5:0]};
			3'd3:    cp = {5'd0, fin_seq[0][3:0], fin_seq[1][5:0], fin_seq[2][5:0]};
			default: cp = {fin_seq[0][2:0], fin_seq[1][5:0], fin_seq[2][5:0],
				fin_seq[3][5:0]};
		endcase
	end

	always_comb begin
		avail = cnt_t'(OUT_LIMIT + 1) - cnt_q;
		if (!fin || cp_removed(cp)) begin
			n_emit = 3'd0;
		end else if (avail < cnt_t'(fin_len)) begin
			n_emit = avail[2:0];
		end else begin
			n_emit = fin_len;
		end
		n_total = (last_s1 && n_emit == 3'd0) ? 3'd1 : n_emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q <= 3'd0;
			have_q <= 3'd0;
			cnt_q  <= '0;
		end else if (proc) begin
			if (last_s1) begin
				need_q <= 3'd0;
				have_q <= 3'd0;
				cnt_q  <= '0;
			end else begin
				need_q <= need_d;
				have_q <= have_d;
				cnt_q  <= cnt_q + cnt_t'(n_emit);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			held_q     <= held_d;
			buf_q      <= fin_seq;
			buf_last_q <= last_s1;
			marker_q   <= (n_emit == 3'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (proc) begin
			rem_q <= n_total;
			idx_q <= 2'd0;
		end else if (out_fire) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	assign out_ch.valid      = (rem_q != 3'd0);
	assign out_ch.out_byte   = marker_q ? 8'd0 : buf_q[idx_q];
	assign out_ch.byte_valid = !marker_q;
	assign out_ch.out_last   = buf_last_q && (rem_q == 3'd1);

`ifndef SYNTHESIS
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'd4)
		else $error("output buffer holds more than four bytes");

	a_need_legal: assert property (@(posedge clk) disable iff (!arst_n)
		need_q != 3'd1 && need_q <= 3'd4)
		else $error("pending sequence length is illegal");

	a_have_below_need: assert property (@(posedge clk) disable iff (!arst_n)
		(need_q == 3'd0 && have_q == 3'd0) || (need_q != 3'd0 && have_q < need_q))
		else $error("received count disagrees with pending length");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(OUT_LIMIT + 1))
		else $error("emitted byte count exceeds the limit");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.byte_valid |-> out_ch.out_last && rem_q == 3'd1)
		else $error("bare end marker is not the final item");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte strings into the UTF-8 code point range filter and checks each
// output item against a decoder and range filter written inside the bench, or
// against the item written in a typed directed row. A short table of directed
// bytes comes first. It is followed by a string aligned to the output limit
// and by random short strings built from well-formed, removed, truncated and
// stray sequences. Both channels idle at random, except in the final stretch.
// ----------------------------------------------------------------------------
module testbench
	import ucf_pkg::*;
();

	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_ITEMS  = 150;
	localparam int QUIET_ITEMS   = 40;
	localparam int NUM_CUTS      = 20;
	localparam int DIRECTED_ROWS = 24;

	localparam int unsigned CUT_LO [NUM_CUTS] = '{
		'h00000, 'h0000B, 'h0000E, 'h0007F, 'h02700, 'h1F600, 'h1F300,
		'h1F900, 'h1F680, 'h02600, 'h02300, 'h02190, 'h02E80, 'h03000,
		'hE0000, 'hFE000, 'h0FE00, 'h0200B, 'h02028, 'h02060
	};
	localparam int unsigned CUT_HI [NUM_CUTS] = '{
		'h00008, 'h0000C, 'h0001F, 'h0009F, 'h027BF, 'h1F64F, 'h1F5FF,
		'h1F9FF, 'h1F6FF, 'h026FF, 'h023FF, 'h021FF, 'h02EFF, 'h0303F,
		'hE007F, 'hFE0FF, 'h0FE0F, 'h0200F, 'h0202E, 'h02064
	};

	typedef struct packed {
		byte_t dbyte;
		logic  dvalid;
		logic  dlast;
	} filt_res_t;

	typedef struct {
		byte_t     b;
		logic      lst;
		bit        typed;
		int        tn;
		filt_res_t tr;
	} dir_row_t;

	// Rows marked typed carry their output item as written; the rest are predicted.
	dir_row_t directed_rows [DIRECTED_ROWS] = '{
		'{8'h41, 1'b0, 1'b1, 1, '{8'h41, 1'b1, 1'b0}},
		'{8'h00, 1'b0, 1'b1, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h7F, 1'b0, 1'b1, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h80, 1'b0, 1'b1, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'hFF, 1'b1, 1'b1, 1, '{8'h00, 1'b0, 1'b1}},
		'{8'hC3, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'hA9, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'hC1, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h81, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'hE2, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h9C, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h93, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'hE2, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h82, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h41, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'hF0, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h90, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h80, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h80, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'hF0, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h9F, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h8C, 1'b0, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'h42, 1'b1, 1'b0, 0, '{8'h00, 1'b0, 1'b0}},
		'{8'hC3, 1'b1, 1'b1, 1, '{8'h00, 1'b0, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n;

	ucf_in_if  in_ch ();
	ucf_out_if out_ch ();

	utf8_codepoint_range_filter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #2 clk = ~clk;

	filt_res_t filtered_q [$];
	filt_res_t step_out [$];
	byte_t     str_bytes [$];

	byte_t pend_bytes [3];
	int    pend_need;
	int    pend_have;
	int    out_count;

	bit idle_on;
	int mismatch_count;
	int cycle_count;
	int items_sent;
	int strings_sent;
	int results_checked;
	int limit_refusals;

	function automatic bit cp_is_cut(input int unsigned cp);
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_CUTS; i++) begin
			if (cp >= CUT_LO[i] && cp <= CUT_HI[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function void keep_if_allowed(input byte_t sq [4], input int len);
		int unsigned cp;
		case (len)
			1: cp = sq[0];
			2: cp = {sq[0][4:0], sq[1][5:0]};
			3: cp = {sq[0][3:0], sq[1][5:0], sq[2][5:0]};
			default: cp = {sq[0][2:0], sq[1][5:0], sq[2][5:0], sq[3][5:0]};
		endcase
		if (cp_is_cut(cp)) begin
			return;
		end
		for (int i = 0; i < len && out_count < OUT_LIMIT + 1; i++) begin
			step_out.push_back('{dbyte: sq[i], dvalid: 1'b1, dlast: 1'b0});
			out_count++;
		end
	endfunction

	function void try_start(input byte_t b);
		int    len;
		byte_t one [4];
		if (out_count >= OUT_LIMIT) begin
			limit_refusals++;
			return;
		end
		casez (b)
			8'b0???????: len = 1;
			8'b110?????: len = 2;
			8'b1110????: len = 3;
			8'b11110???: len = 4;
			default:     len = 0;
		endcase
		if (len == 0) begin
			return;
		end
		if (len == 1) begin
			one = '{b, 8'h00, 8'h00, 8'h00};
			keep_if_allowed(one, 1);
			return;
		end
		pend_bytes[0] = b;
		pend_need     = len;
		pend_have     = 1;
	endfunction

	function void decode_and_filter(input byte_t b, input logic lst);
		byte_t sq [4];
		int    len;
		step_out.delete();
		sq = '{8'h00, 8'h00, 8'h00, 8'h00};
		if (pend_need == 0) begin
			try_start(b);
		end else if (b[7:6] == 2'b10) begin
			if (pend_have + 1 >= pend_need) begin
				len = pend_need;
				for (int i = 0; i < len - 1; i++) begin
					sq[i] = pend_bytes[i];
				end
				sq[len-1] = b;
				pend_need = 0;
				pend_have = 0;
				keep_if_allowed(sq, len);
			end else begin
				pend_bytes[pend_have % 3] = b;
				pend_have++;
			end
		end else begin
			pend_need = 0;
			pend_have = 0;
			try_start(b);
		end
		if (lst) begin
			if (step_out.size() == 0) begin
				step_out.push_back('{dbyte: 8'h00, dvalid: 1'b0, dlast: 1'b0});
			end
			step_out[step_out.size()-1].dlast = 1'b1;
			pend_need = 0;
			pend_have = 0;
			out_count = 0;
		end
	endfunction

	function void add_encoded(input int unsigned cp, input int len);
		case (len)
			1: str_bytes.push_back({1'b0, cp[6:0]});
			2: begin
				str_bytes.push_back({3'b110, cp[10:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				str_bytes.push_back({4'b1110, cp[15:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				str_bytes.push_back({5'b11110, cp[20:18]});
				str_bytes.push_back({2'b10, cp[17:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function void add_random_unit(input bit dense);
		int          pick;
		int          len;
		int          minlen;
		int          r;
		int unsigned cp;
		int unsigned mask;
		pick = dense ? $urandom_range(0, 54) : $urandom_range(0, 99);
		if (pick < 55 || pick >= 75 && pick < 87) begin
			len = (pick < 55) ? $urandom_range(1, 4) : $urandom_range(2, 4);
			case (len)
				1: mask = 'h7F;
				2: mask = 'h7FF;
				3: mask = 'hFFFF;
				default: mask = 'h1FFFFF;
			endcase
			cp = $urandom & mask;
			add_encoded(cp, len);
			if (pick >= 55) begin
				repeat ($urandom_range(1, len - 1)) str_bytes.pop_back();
			end
		end else if (pick < 75) begin
			r = $urandom_range(0, NUM_CUTS - 1);
			case ($urandom_range(0, 4))
				0: cp = CUT_LO[r];
				1: cp = CUT_HI[r];
				2: cp = (CUT_LO[r] == 0) ? 0 : CUT_LO[r] - 1;
				3: cp = CUT_HI[r] + 1;
				default: cp = $urandom_range(CUT_LO[r], CUT_HI[r]);
			endcase
			minlen = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(minlen, 4) : minlen;
			add_encoded(cp, len);
		end else begin
			str_bytes.push_back(byte_t'($urandom_range(0, 255)));
		end
	endfunction

	task report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
	endtask

	task send_item(input byte_t b, input logic lst, input bit typed, input int tn,
		input filt_res_t tr);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= lst;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
		if (lst) begin
			strings_sent++;
		end
		decode_and_filter(b, lst);
		if (typed) begin
			if (tn != 0) begin
				filtered_q.push_back(tr);
			end
		end else begin
			foreach (step_out[i]) filtered_q.push_back(step_out[i]);
		end
	endtask

	task send_string();
		foreach (str_bytes[i]) begin
			send_item(str_bytes[i], i == str_bytes.size() - 1, 1'b0, 0, '0);
		end
	endtask

	task wait_drained();
		while (filtered_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_out
		filt_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (filtered_q.size() == 0) begin
				report_mismatch($sformatf("unexpected output item, byte %02h valid %0b last %0b",
					out_ch.out_byte, out_ch.byte_valid, out_ch.out_last));
			end else begin
				want = filtered_q.pop_front();
				results_checked++;
				if (out_ch.out_byte !== want.dbyte) begin
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						out_ch.out_byte, want.dbyte));
				end
				if (out_ch.byte_valid !== want.dvalid) begin
					report_mismatch($sformatf("byte_valid %0b, expected %0b",
						out_ch.byte_valid, want.dvalid));
				end
				if (out_ch.out_last !== want.dlast) begin
					report_mismatch($sformatf("out_last %0b, expected %0b",
						out_ch.out_last, want.dlast));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("utf8_codepoint_range_filter verification failed");
			$finish;
		end
	end

	initial begin : sink_side
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : source_side
		int random_items;
		int target;
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.in_byte   = 8'h00;
		in_ch.in_last   = 1'b0;
		idle_on         = 1'b1;
		pend_bytes      = '{8'h00, 8'h00, 8'h00};
		pend_need       = 0;
		pend_have       = 0;
		out_count       = 0;
		mismatch_count  = 0;
		cycle_count     = 0;
		items_sent      = 0;
		strings_sent    = 0;
		results_checked = 0;
		limit_refusals  = 0;
		random_items    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].b, directed_rows[i].lst, directed_rows[i].typed,
				directed_rows[i].tn, directed_rows[i].tr);
		end
		in_ch.valid <= 1'b0;
		wait_drained();

		// Fill to one byte short of the limit so that a four-byte sequence is cut in half.
		str_bytes.delete();
		repeat (OUT_LIMIT - 1) str_bytes.push_back(byte_t'($urandom_range(8'h20, 8'h7E)));
		add_encoded('h10000 + $urandom_range(0, 'hFFF), 4);
		str_bytes.push_back(8'h41);
		str_bytes.push_back(8'h42);
		send_string();

		while (random_items < RANDOM_ITEMS) begin
			if (random_items >= RANDOM_ITEMS - QUIET_ITEMS) begin
				idle_on = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				idle_on = ~idle_on;
			end
			target = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
			str_bytes.delete();
			while (str_bytes.size() < target) add_random_unit($urandom_range(0, 3) == 0);
			while (str_bytes.size() > target) str_bytes.pop_back();
			send_string();
			random_items += target;
			if (idle_on && $urandom_range(0, 5) == 0) begin
				in_ch.valid <= 1'b0;
				wait_drained();
			end
		end
		in_ch.valid <= 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d input items in %0d strings; %0d output items compared.",
			items_sent, strings_sent, results_checked);
		$display("Sequence starts refused at the output limit: %0d.", limit_refusals);
		if (mismatch_count == 0) begin
			$display("utf8_codepoint_range_filter verification clean");
		end else begin
			$display("utf8_codepoint_range_filter verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/ucf_pkg.sv
rtl/ucf_in_if.sv
rtl/ucf_out_if.sv
rtl/utf8_codepoint_range_filter.sv
tb/testbench.sv
